### hw/rtl/mpeg_stream_start_code_recogniser_unit_defines.svh
// assertion macros for the mpeg start code recogniser checker
// no dependencies; included by the checker file only
`ifndef MPEG_STREAM_START_CODE_RECOGNISER_UNIT_DEFINES_SVH
`define MPEG_STREAM_START_CODE_RECOGNISER_UNIT_DEFINES_SVH

// same-cycle implication, disabled during reset
`define MSCRU_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled during reset
`define MSCRU_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### hw/rtl/mscru_pkg.sv
// shared types, codes and lookup for the mpeg start code recogniser
// no dependencies; used by the top level, both checkers and the testbench
package mscru_pkg;

  localparam int unsigned CfgIdxW = 2;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_EXT_MATCHED      = 2'd0,
    CFG_SOURCE_IS_BUFFER = 2'd1
  } cfg_idx_e;

  // parse phase, one-hot
  typedef enum logic [4:0] {
    PH_CODE  = 5'b00001,
    PH_PACK  = 5'b00010,
    PH_SKIP  = 5'b00100,
    PH_MPEG2 = 5'b01000,
    PH_LEN   = 5'b10000
  } phase_e;

  // internal stop state
  typedef enum logic [1:0] {
    STOP_NONE    = 2'd0,
    STOP_END     = 2'd1,
    STOP_CORRUPT = 2'd2
  } stop_e;

  // stop reason as reported
  localparam logic [1:0] REASON_END     = 2'd0;
  localparam logic [1:0] REASON_CORRUPT = 2'd1;
  localparam logic [1:0] REASON_RAN_OUT = 2'd2;

  // confidence levels
  localparam logic [1:0] CONF_NONE     = 2'd0;
  localparam logic [1:0] CONF_POSSIBLE = 2'd1;
  localparam logic [1:0] CONF_PROBABLE = 2'd2;
  localparam logic [1:0] CONF_CERTAIN  = 2'd3;

  // type select codes
  localparam logic [2:0] TYPE_NONE = 3'd0;
  localparam logic [2:0] TYPE_EXT  = 3'd4;

  // start code bytes and masks
  localparam logic [31:0] CODE_MASK   = 32'hffff_ff00;
  localparam logic [31:0] CODE_PREFIX = 32'h0000_0100;
  localparam logic [7:0]  SC_PACK     = 8'hBA;
  localparam logic [7:0]  SC_VIDEO    = 8'hE0;
  localparam logic [7:0]  SC_END      = 8'hB9;
  localparam logic [7:0]  PACK_MPEG1  = 8'h21;
  localparam logic [7:0]  PACK_MPEG2  = 8'h44;

  localparam logic [3:0]  CODE_BYTES  = 4'd4;
  localparam logic [3:0]  LEN_BYTES   = 4'd2;
  localparam logic [3:0]  MPEG2_BYTES = 4'd9;
  localparam logic [15:0] MPEG1_SKIP  = 16'd7;

  // index is {code_two, code_one, ext}
  function automatic logic [1:0] conf_lut(input logic [2:0] idx);
    logic [1:0] c;
    case (idx)
      3'd0:    c = CONF_NONE;
      3'd1:    c = CONF_POSSIBLE;
      3'd2:    c = CONF_POSSIBLE;
      3'd3:    c = CONF_PROBABLE;
      3'd4:    c = CONF_NONE;
      3'd5:    c = CONF_NONE;
      3'd6:    c = CONF_PROBABLE;
      default: c = CONF_CERTAIN;
    endcase
    return c;
  endfunction

endpackage

### hw/rtl/mpeg_stream_start_code_recogniser_unit.sv
// mpeg program stream start code recogniser, top level
// depends on mscru_pkg
// a result is held in the output register from the cycle after its last byte is taken
// throughput: one byte per cycle while the input is not stalled, as the parse state updates on each taken byte
// the input stalls only while a finished result is held by a stalled output
// reset (async, active low) clears parse state, both config registers and result valid
module mpeg_stream_start_code_recogniser_unit
  import mscru_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration write port
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic               cfg_data_i,
  // byte requests
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         data_byte_i,
  input  logic               last_byte_i,
  // result requests
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         confidence_o,
  output logic [2:0]         type_select_o,
  output logic [1:0]         stop_reason_o
);

  // configuration registers
  logic ext_q, buf_q;

  // parse state
  phase_e      phase_q, phase_d;
  logic [3:0]  cnt_q, cnt_d;
  logic [31:0] shift_q, shift_d;
  logic [15:0] skip_q, skip_d;
  logic        one_q, one_d;
  logic        two_q, two_d;
  logic        video_q, video_d;
  logic        mpeg1_q, mpeg1_d;
  stop_e       stop_q, stop_d;

  // output register
  logic       out_valid_q;
  logic [1:0] conf_q, conf_d;
  logic [2:0] type_q, type_d;
  logic [1:0] reason_q, reason_d;

  logic        in_acc;
  logic [3:0]  cnt_inc;
  logic [15:0] skip_dec;
  logic        skip_start;
  logic [15:0] skip_len;
  logic [2:0]  conf_idx;
  logic        video_any;

  // the input waits only while a held result cannot leave
  assign in_stall_o = out_valid_q & out_stall_i;
  assign in_acc     = in_valid_i & ~in_stall_o;

  // configuration writes, unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ext_q <= 1'b0;
      buf_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_EXT_MATCHED:      ext_q <= cfg_data_i;
        CFG_SOURCE_IS_BUFFER: buf_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // parse one byte
  always_comb begin
    phase_d    = phase_q;
    cnt_d      = cnt_q;
    shift_d    = shift_q;
    skip_d     = skip_q;
    one_d      = one_q;
    two_d      = two_q;
    video_d    = video_q;
    mpeg1_d    = mpeg1_q;
    stop_d     = stop_q;
    skip_start = 1'b0;
    skip_len   = '0;
    cnt_inc    = cnt_q + 4'd1;
    skip_dec   = skip_q - {15'd0, (skip_q != 16'd0)};

    // once stopped, bytes are ignored until the last one
    if (stop_q == STOP_NONE) begin
      unique case (phase_q)
        PH_CODE: begin
          // collect four bytes of a big-endian start code
          shift_d = {shift_q[23:0], data_byte_i};
          cnt_d   = cnt_inc;
          if (cnt_inc >= CODE_BYTES) begin
            cnt_d = '0;
            if ((shift_d & CODE_MASK) != CODE_PREFIX) begin
              stop_d = STOP_CORRUPT;
            end else begin
              // first and second valid codes
              if (!one_q) begin
                one_d = 1'b1;
              end else if (!two_q) begin
                two_d = 1'b1;
              end
              unique case (shift_d[7:0])
                SC_PACK:  phase_d = PH_PACK;
                SC_VIDEO: begin
                  video_d = 1'b1;
                  stop_d  = STOP_END;
                end
                SC_END:   stop_d = STOP_END;
                default: begin
                  // other codes carry a 16-bit length
                  phase_d = PH_LEN;
                  shift_d = '0;
                end
              endcase
            end
          end
        end
        PH_PACK: begin
          // first pack byte tells mpeg-1 from mpeg-2
          if ((data_byte_i & PACK_MPEG1) == PACK_MPEG1) begin
            mpeg1_d    = 1'b1;
            skip_start = 1'b1;
            skip_len   = MPEG1_SKIP;
          end else if ((data_byte_i & PACK_MPEG2) == PACK_MPEG2) begin
            phase_d = PH_MPEG2;
            cnt_d   = '0;
          end else begin
            stop_d = STOP_CORRUPT;
          end
        end
        PH_MPEG2: begin
          // last header byte gives the stuffing length
          cnt_d = cnt_inc;
          if (cnt_inc >= MPEG2_BYTES) begin
            skip_start = 1'b1;
            skip_len   = {13'd0, data_byte_i[2:0]};
          end
        end
        PH_LEN: begin
          shift_d = {16'd0, shift_q[7:0], data_byte_i};
          cnt_d   = cnt_inc;
          if (cnt_inc >= LEN_BYTES) begin
            skip_start = 1'b1;
            skip_len   = shift_d[15:0];
          end
        end
        PH_SKIP: begin
          skip_d = skip_dec;
          if (skip_dec == 16'd0) begin
            phase_d = PH_CODE;
          end
        end
        default: begin
          phase_d = PH_CODE;
          cnt_d   = '0;
        end
      endcase

      // start of a byte skip, a zero length goes straight back to codes
      if (skip_start) begin
        skip_d  = skip_len;
        cnt_d   = '0;
        shift_d = '0;
        phase_d = (skip_len == 16'd0) ? PH_CODE : PH_SKIP;
      end
    end
  end

  // result from the state after this byte
  always_comb begin
    conf_idx  = {two_d, one_d, ext_q};
    conf_d    = conf_lut(conf_idx);
    video_any = video_d | buf_q;
    if (conf_d == CONF_NONE) begin
      type_d = TYPE_NONE;
    end else if (conf_idx == 3'd1) begin
      // extension match alone
      type_d = TYPE_EXT;
    end else begin
      type_d = {1'b0, mpeg1_d, video_any};
    end
    case (stop_d)
      STOP_END:     reason_d = REASON_END;
      STOP_CORRUPT: reason_d = REASON_CORRUPT;
      default:      reason_d = REASON_RAN_OUT;
    endcase
  end

  // parse state, cleared after the last byte of a file
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_CODE;
      cnt_q   <= '0;
      shift_q <= '0;
      skip_q  <= '0;
      one_q   <= 1'b0;
      two_q   <= 1'b0;
      video_q <= 1'b0;
      mpeg1_q <= 1'b0;
      stop_q  <= STOP_NONE;
    end else if (in_acc) begin
      if (last_byte_i) begin
        phase_q <= PH_CODE;
        cnt_q   <= '0;
        shift_q <= '0;
        skip_q  <= '0;
        one_q   <= 1'b0;
        two_q   <= 1'b0;
        video_q <= 1'b0;
        mpeg1_q <= 1'b0;
        stop_q  <= STOP_NONE;
      end else begin
        phase_q <= phase_d;
        cnt_q   <= cnt_d;
        shift_q <= shift_d;
        skip_q  <= skip_d;
        one_q   <= one_d;
        two_q   <= two_d;
        video_q <= video_d;
        mpeg1_q <= mpeg1_d;
        stop_q  <= stop_d;
      end
    end
  end

  // output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_acc && last_byte_i) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk_i) begin
    if (in_acc && last_byte_i) begin
      conf_q   <= conf_d;
      type_q   <= type_d;
      reason_q <= reason_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign confidence_o  = conf_q;
  assign type_select_o = type_q;
  assign stop_reason_o = reason_q;

endmodule

### hw/rtl/mscru_checker.sv
// port-level checker for the mpeg start code recogniser, bound to the top level
// depends on mscru_pkg and mpeg_stream_start_code_recogniser_unit_defines.svh
`include "mpeg_stream_start_code_recogniser_unit_defines.svh"

module mscru_checker
  import mscru_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       last_byte_i,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [1:0] confidence_o,
  input logic [2:0] type_select_o,
  input logic [1:0] stop_reason_o
);

  logic in_acc;
  assign in_acc = in_valid_i & ~in_stall_o;

  // a new result only follows a taken last byte
  `MSCRU_ASSERT_IMP(a_result_after_last, clk_i, rst_ni, $rose(out_valid_o), $past(in_acc && last_byte_i), "result without a last byte")

  // a byte that is not last never makes a result
  `MSCRU_ASSERT_NXT(a_no_spurious_result, clk_i, rst_ni, !out_valid_o && in_acc && !last_byte_i, !out_valid_o, "result from a byte that was not last")

  // extension type only with possible confidence
  `MSCRU_ASSERT_IMP(a_ext_type_conf, clk_i, rst_ni, out_valid_o && type_select_o == TYPE_EXT, confidence_o == CONF_POSSIBLE, "extension type with wrong confidence")

  // a stalled result holds
  `MSCRU_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(confidence_o) && $stable(type_select_o) && $stable(stop_reason_o), "stalled result changed")

endmodule

bind mpeg_stream_start_code_recogniser_unit mscru_checker u_mscru_checker (.*);

### verif/mpeg_stream_start_code_recogniser_unit_checker.sv
// result checker for the mpeg start code recogniser: predicts each verdict from the
// accepted byte requests and register writes, then compares accepted results in order
// depends on mscru_pkg
module mpeg_stream_start_code_recogniser_unit_checker
  import mscru_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic               cfg_data_i,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic [7:0]         data_byte_i,
  input  logic               last_byte_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic [1:0]         confidence_i,
  input  logic [2:0]         type_select_i,
  input  logic [1:0]         stop_reason_i,
  output int                 mismatch_count_o,
  output int                 verdicts_due_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [1:0] confidence;
    logic [2:0] type_select;
    logic [1:0] stop_reason;
  } verdict_t;

  logic        ext_seen;
  logic        buffer_src;
  phase_e      scan_phase;
  logic [3:0]  field_count;
  logic [31:0] code_window;
  logic [15:0] skip_left;
  logic        code_one;
  logic        code_two;
  logic        video_flag;
  logic        mpeg1_flag;
  stop_e       halt;

  verdict_t verdicts_due[$];
  int       mismatches = 0;

  task automatic clear_scan();
    scan_phase  = PH_CODE;
    field_count = '0;
    code_window = '0;
    skip_left   = '0;
    code_one    = 1'b0;
    code_two    = 1'b0;
    video_flag  = 1'b0;
    mpeg1_flag  = 1'b0;
    halt        = STOP_NONE;
  endtask

  task automatic start_skip(input logic [15:0] n);
    skip_left   = n;
    field_count = '0;
    code_window = '0;
    scan_phase  = (n == 16'd0) ? PH_CODE : PH_SKIP;
  endtask

  // advance the parse by one byte; on the final byte queue the verdict and clear
  task automatic scan_byte(input logic [7:0] b, input logic fin);
    logic [2:0] idx;
    verdict_t   v;
    if (halt == STOP_NONE) begin
      case (scan_phase)
        PH_CODE: begin
          code_window = {code_window[23:0], b};
          field_count = field_count + 4'd1;
          if (field_count >= CODE_BYTES) begin
            field_count = '0;
            if ((code_window & CODE_MASK) != CODE_PREFIX) begin
              halt = STOP_CORRUPT;
            end else begin
              if (!code_one) code_one = 1'b1;
              else if (!code_two) code_two = 1'b1;
              case (code_window[7:0])
                SC_PACK: scan_phase = PH_PACK;
                SC_VIDEO: begin
                  video_flag = 1'b1;
                  halt       = STOP_END;
                end
                SC_END: halt = STOP_END;
                default: begin
                  scan_phase  = PH_LEN;
                  code_window = '0;
                end
              endcase
            end
          end
        end
        PH_PACK: begin
          if ((b & PACK_MPEG1) == PACK_MPEG1) begin
            mpeg1_flag = 1'b1;
            start_skip(MPEG1_SKIP);
          end else if ((b & PACK_MPEG2) == PACK_MPEG2) begin
            scan_phase  = PH_MPEG2;
            field_count = '0;
          end else begin
            halt = STOP_CORRUPT;
          end
        end
        PH_MPEG2: begin
          field_count = field_count + 4'd1;
          if (field_count >= MPEG2_BYTES) start_skip({13'd0, b[2:0]});
        end
        PH_LEN: begin
          code_window = {16'd0, code_window[7:0], b};
          field_count = field_count + 4'd1;
          if (field_count >= LEN_BYTES) start_skip(code_window[15:0]);
        end
        PH_SKIP: begin
          if (skip_left != 16'd0) skip_left = skip_left - 16'd1;
          if (skip_left == 16'd0) scan_phase = PH_CODE;
        end
        default: begin
          scan_phase  = PH_CODE;
          field_count = '0;
        end
      endcase
    end
    if (fin) begin
      idx = {code_two, code_one, ext_seen};
      case (idx)
        3'b001, 3'b010: v.confidence = CONF_POSSIBLE;
        3'b011, 3'b110: v.confidence = CONF_PROBABLE;
        3'b111:         v.confidence = CONF_CERTAIN;
        default:        v.confidence = CONF_NONE;
      endcase
      if (v.confidence == CONF_NONE) v.type_select = TYPE_NONE;
      else if (idx == 3'b001) v.type_select = TYPE_EXT;
      else v.type_select = {1'b0, mpeg1_flag, video_flag | buffer_src};
      case (halt)
        STOP_END:     v.stop_reason = REASON_END;
        STOP_CORRUPT: v.stop_reason = REASON_CORRUPT;
        default:      v.stop_reason = REASON_RAN_OUT;
      endcase
      verdicts_due.push_back(v);
      clear_scan();
    end
  endtask

  task automatic check_verdict();
    verdict_t v;
    if (verdicts_due.size() == 0) begin
      $display("%0t: result with none expected (conf %0d type %0d reason %0d)",
               $time, confidence_i, type_select_i, stop_reason_i);
      mismatches++;
    end else begin
      v = verdicts_due.pop_front();
      if (confidence_i !== v.confidence) begin
        $display("%0t: confidence expected %0d, actual %0d", $time, v.confidence, confidence_i);
        mismatches++;
      end
      if (type_select_i !== v.type_select) begin
        $display("%0t: type_select expected %0d, actual %0d", $time, v.type_select,
                 type_select_i);
        mismatches++;
      end
      if (stop_reason_i !== v.stop_reason) begin
        $display("%0t: stop_reason expected %0d, actual %0d", $time, v.stop_reason,
                 stop_reason_i);
        mismatches++;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ext_seen   = 1'b0;
      buffer_src = 1'b0;
      clear_scan();
      verdicts_due.delete();
      mismatch_count_o <= mismatches;
      verdicts_due_o   <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_EXT_MATCHED:      ext_seen   = cfg_data_i;
          CFG_SOURCE_IS_BUFFER: buffer_src = cfg_data_i;
          default: ;
        endcase
      end
      // results first: a byte taken this edge cannot have its result out yet
      if (out_valid_i && !out_stall_i) check_verdict();
      if (in_valid_i && !in_stall_i) scan_byte(data_byte_i, last_byte_i);
      mismatch_count_o <= mismatches;
      verdicts_due_o   <= verdicts_due.size();
    end
  end

endmodule

### verif/mpeg_stream_start_code_recogniser_unit_tb.sv
// top level testbench for the mpeg start code recogniser: clock, reset, byte streams,
// register writes, result stalls and the final verdict
// depends on mscru_pkg, the recogniser and its checker
module mpeg_stream_start_code_recogniser_unit_tb;
  import mscru_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // spare register indexes, writes there must change nothing
  localparam logic [CfgIdxW-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_SPARE_HI = 2'd3;

  localparam int PHASES       = 8;
  localparam int HOLD_PHASE   = 2;   // phase in which the receiver holds off for long
  localparam int HOLD_CYCLES  = 60;
  localparam int SETTLE       = 4;   // cycles left before a register write
  localparam int DRAIN_CYCLES = 10;  // ample, since a result is registered as its last byte is taken
  localparam int PHASE_BYTES  = 40;
  localparam int PHASE_FILES  = 1;

  typedef enum int {PKT_MPEG1, PKT_MPEG2, PKT_OTHER} pkt_e;
  typedef enum int {TAIL_VIDEO, TAIL_END, TAIL_BROKEN, TAIL_BAD_PACK, TAIL_NONE} tail_e;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [CfgIdxW-1:0] cfg_index_i;
  logic               cfg_data_i;
  logic               in_valid_i;
  logic               in_stall_o;
  logic [7:0]         data_byte_i;
  logic               last_byte_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic [1:0]         confidence_o;
  logic [2:0]         type_select_o;
  logic [1:0]         stop_reason_o;

  int mismatch_count;
  int verdicts_due;

  // 0 turns idling off on both sides, otherwise 1 in idle_odds chance per request
  int   idle_odds;
  logic hold_wanted;

  logic [7:0] file_bytes[$];

  mpeg_stream_start_code_recogniser_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .data_byte_i   (data_byte_i),
    .last_byte_i   (last_byte_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .confidence_o  (confidence_o),
    .type_select_o (type_select_o),
    .stop_reason_o (stop_reason_o)
  );

  mpeg_stream_start_code_recogniser_unit_checker checker_inst (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_stall_i       (in_stall_o),
    .data_byte_i      (data_byte_i),
    .last_byte_i      (last_byte_i),
    .out_valid_i      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .confidence_i     (confidence_o),
    .type_select_i    (type_select_o),
    .stop_reason_i    (stop_reason_o),
    .mismatch_count_o (mismatch_count),
    .verdicts_due_o   (verdicts_due)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // hard stop well beyond the slowest legal run
  initial begin
    #2ms;
    $display("mpeg_stream_start_code_recogniser_unit_tb: done, errors");
    $finish;
  end

  // result side: random stall bursts, plus one long hold-off so that a finished
  // result sits in the output register and the byte input backs up behind it
  initial begin
    bit held_once;
    held_once = 1'b0;
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_wanted && !held_once) begin
        held_once = 1'b1;
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end else if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 9)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  task automatic push_random(input int n);
    repeat (n) file_bytes.push_back(8'($urandom_range(0, 255)));
  endtask

  task automatic push_prefix();
    file_bytes.push_back(8'h00);
    file_bytes.push_back(8'h00);
    file_bytes.push_back(8'h01);
  endtask

  // build one file: mostly a chain of well-formed packets with random content,
  // closed by video, an end code, a damaged code, a bad pack byte or nothing;
  // some files are cut short and some are plain noise
  task automatic compose_stream();
    int          len;
    int          keep;
    logic [7:0]  b;
    logic [31:0] word;
    pkt_e        kind;
    tail_e       ending;
    file_bytes.delete();
    if ($urandom_range(0, 7) == 0) begin
      push_random($urandom_range(1, 8));
      return;
    end
    repeat ($urandom_range(0, 4)) begin
      kind = pkt_e'($urandom_range(0, 2));
      push_prefix();
      case (kind)
        PKT_MPEG1: begin
          file_bytes.push_back(SC_PACK);
          b = 8'($urandom_range(0, 255)) | PACK_MPEG1;
          file_bytes.push_back(b);
          push_random(7);
        end
        PKT_MPEG2: begin
          file_bytes.push_back(SC_PACK);
          b = 8'($urandom_range(0, 255)) | PACK_MPEG2;
          // keep it clear of the mpeg-1 pattern, which is tested first
          if ($urandom_range(0, 1) == 1) b[0] = 1'b0;
          else b[5] = 1'b0;
          file_bytes.push_back(b);
          push_random(8);
          b = 8'($urandom_range(0, 255));
          file_bytes.push_back(b);
          push_random(int'(b[2:0]));
        end
        default: begin
          do b = 8'($urandom_range(0, 255));
          while (b == SC_PACK || b == SC_VIDEO || b == SC_END);
          file_bytes.push_back(b);
          len = ($urandom_range(0, 29) == 0) ? $urandom_range(256, 300) : $urandom_range(0, 12);
          file_bytes.push_back(len[15:8]);
          file_bytes.push_back(len[7:0]);
          push_random(len);
        end
      endcase
    end
    ending = tail_e'($urandom_range(0, 4));
    case (ending)
      TAIL_VIDEO: begin
        push_prefix();
        file_bytes.push_back(SC_VIDEO);
      end
      TAIL_END: begin
        push_prefix();
        file_bytes.push_back(SC_END);
      end
      TAIL_BROKEN: begin
        // one flipped bit somewhere in the 0x000001 prefix
        word = {24'h000001, 8'($urandom_range(0, 255))} ^ (32'd1 << $urandom_range(8, 31));
        file_bytes.push_back(word[31:24]);
        file_bytes.push_back(word[23:16]);
        file_bytes.push_back(word[15:8]);
        file_bytes.push_back(word[7:0]);
      end
      TAIL_BAD_PACK: begin
        push_prefix();
        file_bytes.push_back(SC_PACK);
        b = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 1) == 1) b[0] = 1'b0;
        else b[5] = 1'b0;
        if ($urandom_range(0, 1) == 1) b[2] = 1'b0;
        else b[6] = 1'b0;
        file_bytes.push_back(b);
      end
      default: ;
    endcase
    push_random($urandom_range(0, 3));
    if (file_bytes.size() > 0 && $urandom_range(0, 3) == 0) begin
      keep = $urandom_range(1, file_bytes.size());
      while (file_bytes.size() > keep) void'(file_bytes.pop_back());
    end
    if (file_bytes.size() == 0) push_random(1);
  endtask

  // offer the file's bytes as requests, the final one flagged last; valid stays
  // high between files and is lowered only for an idle burst or by wait_idle
  task automatic send_file();
    int i;
    for (i = 0; i < file_bytes.size(); i++) begin
      if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk_i);
      end
      in_valid_i  <= 1'b1;
      data_byte_i <= file_bytes[i];
      last_byte_i <= (i == file_bytes.size() - 1);
      do @(posedge clk_i); while (in_stall_o);
    end
  endtask

  // stop offering and wait for every expected result, then a quiet settle period
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (verdicts_due != 0);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // both registers, then a spare index with random data that must be ignored
  task automatic write_regs(input logic ext, input logic buffered);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CFG_EXT_MATCHED;
    cfg_data_i  <= ext;
    @(posedge clk_i);
    cfg_index_i <= CFG_SOURCE_IS_BUFFER;
    cfg_data_i  <= buffered;
    @(posedge clk_i);
    cfg_index_i <= ($urandom_range(0, 1) == 1) ? CFG_SPARE_LO : CFG_SPARE_HI;
    cfg_data_i  <= 1'($urandom_range(0, 1));
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    int p;
    int phase_bytes;
    int phase_files;
    rst_ni      <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_index_i <= CFG_EXT_MATCHED;
    cfg_data_i  <= 1'b0;
    in_valid_i  <= 1'b0;
    data_byte_i <= 8'h00;
    last_byte_i <= 1'b0;
    idle_odds   <= 0;
    hold_wanted <= 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed files, extension flag set so that an empty parse gives the
    // extension-only type
    write_regs(1'b1, 1'b0);
    // one byte, data runs out at once
    file_bytes = '{8'hFF};
    send_file();
    // end code completed exactly on the last byte
    file_bytes = '{8'h00, 8'h00, 8'h01, SC_END};
    send_file();
    // video, then a byte after the stop that must be ignored
    file_bytes = '{8'h00, 8'h00, 8'h01, SC_VIDEO, 8'h00};
    send_file();
    // not a start code at all
    file_bytes = '{8'hFF, 8'hFF, 8'hFF, 8'hFF};
    send_file();
    // pack byte matching neither pattern
    file_bytes = '{8'h00, 8'h00, 8'h01, SC_PACK, 8'h00};
    send_file();
    // zero length packet, then an end code as second code
    file_bytes = '{8'h00, 8'h00, 8'h01, 8'hC0, 8'h00, 8'h00,
                   8'h00, 8'h00, 8'h01, SC_END};
    send_file();

    // random phases, each under its own register setting; the first has no
    // idling and the last runs flat out to the end
    for (p = 0; p < PHASES; p++) begin
      wait_idle();
      if (p < 4) write_regs(p[0], p[1]);
      else if (p == PHASES - 1) write_regs(1'b1, 1'b1);
      else write_regs(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      idle_odds <= (p == 0 || p == PHASES - 1) ? 0 : $urandom_range(2, 8);
      if (p == HOLD_PHASE) begin
        // short files keep results coming while the receiver holds off
        hold_wanted <= 1'b1;
        repeat (12) begin
          file_bytes = '{8'h00, 8'h00, 8'h01, SC_END};
          send_file();
        end
      end
      phase_bytes = 0;
      phase_files = 0;
      while (phase_bytes < PHASE_BYTES || phase_files < PHASE_FILES) begin
        compose_stream();
        phase_bytes += file_bytes.size();
        phase_files++;
        send_file();
      end
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && verdicts_due == 0) begin
      $display("mpeg_stream_start_code_recogniser_unit_tb: done, clean");
    end else begin
      $display("mpeg_stream_start_code_recogniser_unit_tb: done, errors");
    end
    $finish;
  end

endmodule
